/* rtl/interval_timer_channel_top_assert.svh */
// Assertion macros for the interval timer channel.
`ifndef INTERVAL_TIMER_CHANNEL_TOP_ASSERT_SVH
`define INTERVAL_TIMER_CHANNEL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ITC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval timer channel: implication failed");
// Next-cycle implication, disabled while reset is high.
`define ITC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval timer channel: next-cycle check failed");
`else
`define ITC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ITC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/itc_pkg.sv */
package itc_pkg;

  // Width of the down counter and of the reload register.
  localparam int CNT_BITS = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PORT_DATA = 2'd0,
    PORT_CH1  = 2'd1,
    PORT_CH2  = 2'd2,
    PORT_CMD  = 2'd3
  } port_sel_t;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LOW   = 2'd1,
    ACC_HIGH  = 2'd2,
    ACC_BOTH  = 2'd3
  } access_t;

  localparam logic [2:0] MODE_ONESHOT   = 3'd0;
  localparam logic [2:0] MODE_HW_ONESHOT = 3'd1;
  localparam logic [2:0] MODE_RATE      = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_STROBE    = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  localparam logic [1:0] CHANNEL_ZERO = 2'd0;

  typedef struct packed {
    opcode_t     opcode;
    port_sel_t   port;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_level;
    logic       irq_pulse;
  } result_t;

endpackage

/* rtl/itc_core.sv */
module itc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  itc_pkg::item_t  item,
  output itc_pkg::result_t result
);
  import itc_pkg::*;

  logic [CNT_BITS-1:0] count_value, count_value_next;
  logic [CNT_BITS-1:0] reload_value, reload_value_next;
  logic [2:0]          op_mode, op_mode_next;
  access_t             access_kind, access_kind_next;
  logic                write_high, write_high_next;
  logic                read_high, read_high_next;
  logic [7:0]          low_byte_hold, low_byte_hold_next;
  logic [CNT_BITS-1:0] latched_count, latched_count_next;
  logic                latch_held, latch_held_next;
  logic                out_pin, out_pin_next;
  logic                counting, counting_next;
  logic                strobe_spent, strobe_spent_next;

  logic                do_load;
  logic                read_done;
  logic [2:0]          cmd_mode;
  logic [15:0]         read_src;
  logic [7:0]          rd_byte;
  logic [CNT_BITS-1:0] dec1, dec2;

  // Start value of a square-wave half period: odd counts are evened up
  // or down depending on which half is starting.
  function automatic logic [CNT_BITS-1:0] sq_start(input logic [CNT_BITS-1:0] n,
                                                   input logic pin);
    logic [CNT_BITS-1:0] r;
    r = n;
    if (n[0]) begin
      r = pin ? (n + CNT_BITS'(1)) : (n - CNT_BITS'(1));
    end
    return r;
  endfunction

  assign dec1     = count_value - CNT_BITS'(1);
  assign dec2     = count_value - CNT_BITS'(2);
  assign read_src = 16'(latch_held ? latched_count : count_value);
  assign cmd_mode = (item.data[3] && item.data[2]) ? {1'b0, item.data[2:1]} : item.data[3:1];

  always_comb begin
    count_value_next   = count_value;
    reload_value_next  = reload_value;
    op_mode_next       = op_mode;
    access_kind_next   = access_kind;
    write_high_next    = write_high;
    read_high_next     = read_high;
    low_byte_hold_next = low_byte_hold;
    latched_count_next = latched_count;
    latch_held_next    = latch_held;
    out_pin_next       = out_pin;
    counting_next      = counting;
    strobe_spent_next  = strobe_spent;
    do_load            = 1'b0;
    read_done          = 1'b0;
    rd_byte            = 8'h00;

    case (item.opcode)
      OP_WRITE: begin
        if (item.port == PORT_CMD) begin
          if (item.data[7:6] == CHANNEL_ZERO) begin
            if (access_t'(item.data[5:4]) == ACC_LATCH) begin
              if (!latch_held) begin
                latched_count_next = count_value;
                latch_held_next    = 1'b1;
              end
            end else begin
              access_kind_next  = access_t'(item.data[5:4]);
              op_mode_next      = cmd_mode;
              write_high_next   = 1'b0;
              read_high_next    = 1'b0;
              latch_held_next   = 1'b0;
              counting_next     = 1'b0;
              strobe_spent_next = 1'b0;
              out_pin_next      = (cmd_mode != MODE_ONESHOT);
            end
          end
        end else if (item.port == PORT_DATA) begin
          case (access_kind)
            ACC_LOW: begin
              reload_value_next = CNT_BITS'({8'h00, item.data});
              do_load           = 1'b1;
            end
            ACC_HIGH: begin
              reload_value_next = CNT_BITS'({item.data, 8'h00});
              do_load           = 1'b1;
            end
            default: begin
              if (!write_high) begin
                low_byte_hold_next = item.data;
                write_high_next    = 1'b1;
                if (op_mode == MODE_ONESHOT) begin
                  counting_next = 1'b0;
                end
              end else begin
                reload_value_next = CNT_BITS'({item.data, low_byte_hold});
                write_high_next   = 1'b0;
                do_load           = 1'b1;
              end
            end
          endcase
          if (do_load) begin
            if (op_mode == MODE_HW_ONESHOT || op_mode == MODE_HW_STROBE) begin
              counting_next = 1'b0;
            end else if (!((op_mode == MODE_RATE || op_mode == MODE_SQUARE) && counting)) begin
              out_pin_next      = (op_mode != MODE_ONESHOT);
              strobe_spent_next = 1'b0;
              count_value_next  = (op_mode == MODE_SQUARE) ?
                                  sq_start(reload_value_next, op_mode != MODE_ONESHOT) :
                                  reload_value_next;
              counting_next     = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (item.port == PORT_DATA) begin
          case (access_kind)
            ACC_LOW: begin
              rd_byte   = read_src[7:0];
              read_done = 1'b1;
            end
            ACC_HIGH: begin
              rd_byte   = read_src[15:8];
              read_done = 1'b1;
            end
            default: begin
              if (!read_high) begin
                rd_byte        = read_src[7:0];
                read_high_next = 1'b1;
              end else begin
                rd_byte        = read_src[15:8];
                read_high_next = 1'b0;
                read_done      = 1'b1;
              end
            end
          endcase
          if (read_done) begin
            latch_held_next = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (counting) begin
          case (op_mode)
            MODE_ONESHOT: begin
              count_value_next = dec1;
              if (dec1 == '0) begin
                out_pin_next = 1'b1;
              end
            end
            MODE_RATE: begin
              if (count_value == CNT_BITS'(1)) begin
                count_value_next = reload_value;
                out_pin_next     = 1'b1;
              end else begin
                count_value_next = dec1;
                if (dec1 == CNT_BITS'(1)) begin
                  out_pin_next = 1'b0;
                end
              end
            end
            MODE_SQUARE: begin
              if (dec2 == '0) begin
                out_pin_next     = !out_pin;
                count_value_next = sq_start(reload_value, !out_pin);
              end else begin
                count_value_next = dec2;
              end
            end
            MODE_STROBE: begin
              out_pin_next     = 1'b1;
              count_value_next = dec1;
              if (dec1 == '0 && !strobe_spent) begin
                out_pin_next      = 1'b0;
                strobe_spent_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign result.read_data = rd_byte;
  assign result.out_level = out_pin_next;
  assign result.irq_pulse = !out_pin && out_pin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value   <= '0;
      reload_value  <= '0;
      op_mode       <= MODE_ONESHOT;
      access_kind   <= ACC_BOTH;
      write_high    <= 1'b0;
      read_high     <= 1'b0;
      low_byte_hold <= 8'h00;
      latched_count <= '0;
      latch_held    <= 1'b0;
      out_pin       <= 1'b0;
      counting      <= 1'b0;
      strobe_spent  <= 1'b0;
    end else if (step) begin
      count_value   <= count_value_next;
      reload_value  <= reload_value_next;
      op_mode       <= op_mode_next;
      access_kind   <= access_kind_next;
      write_high    <= write_high_next;
      read_high     <= read_high_next;
      low_byte_hold <= low_byte_hold_next;
      latched_count <= latched_count_next;
      latch_held    <= latch_held_next;
      out_pin       <= out_pin_next;
      counting      <= counting_next;
      strobe_spent  <= strobe_spent_next;
    end
  end

endmodule

/* rtl/interval_timer_channel_top.sv */
// An item is held in the input register and its result in the result register.
// Throughput: one item per cycle; ready stays high unless both the input
// register and the result register are full and the result is not taken.
// The rate is set by the single state update in the channel core.
// Reset (synchronous, active high) empties both registers and returns the
// channel to stopped, mode 0, low-then-high access, output low.
`include "interval_timer_channel_top_assert.svh"

module interval_timer_channel_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [1:0] port,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       out_level,
  output logic       irq_pulse
);
  import itc_pkg::*;

  // Input register: holds one accepted item until the core consumes it.
  logic    s1_valid;
  item_t   s1_item;
  // The core consumes the held item whenever the result register can
  // take its result in the same cycle.
  logic    s1_adv;
  result_t core_result;
  result_t out_result;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.opcode <= opcode_t'(opcode);
      s1_item.port   <= port_sel_t'(port);
      s1_item.data   <= write_data;
    end
  end

  // The channel state advances only on the cycle its item moves on, so
  // every item updates the counter exactly once.
  itc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_item),
    .result (core_result)
  );

  // Result register: a finished result waits here for its transfer while
  // the input register can already hold the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result <= core_result;
    end
  end

  assign read_data = out_result.read_data;
  assign out_level = out_result.out_level;
  assign irq_pulse = out_result.irq_pulse;

  `ITC_ASSERT_IMPLIES(a_ready_low_full, clk, rst, !in_ready, s1_valid && out_valid && !out_ready)
  `ITC_ASSERT_IMPLIES(a_no_advance_into_stall, clk, rst, out_valid && !out_ready, !s1_adv)
  `ITC_ASSERT_IMPLIES(a_irq_means_high, clk, rst, out_valid && irq_pulse, out_level)
  `ITC_ASSERT_NEXT(a_advance_gives_result, clk, rst, s1_adv, out_valid)

endmodule

/* bench/interval_timer_channel_top_tb.sv */
module interval_timer_channel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itc_pkg::*;

  // Counted transfers of random stimulus in each of the three idling phases.
  localparam int ITEMS_PER_PHASE = 575;
  // Cycles allowed after the last expected result before the verdict.
  localparam int DRAIN_CYCLES = 10;
  // A command for another channel, which channel 0 must ignore.
  localparam logic [1:0] CHANNEL_ONE = 2'd1;
  // Mode codes 6 and 7 are aliases of the rate and square-wave modes.
  localparam logic [2:0] MODE_RATE_ALIAS = 3'd6;
  localparam logic [2:0] MODE_SQUARE_ALIAS = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] opcode = OP_NOP;
  logic [1:0] port = PORT_DATA;
  logic [7:0] write_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       out_level;
  logic       irq_pulse;

  // Items waiting to be driven, and results that accepted transfers must produce.
  item_t   item_q[$];
  result_t expected_q[$];

  int error_count = 0;
  int stim_count = 0;
  int sender_gap_pct = 20;
  int sink_stall_pct = 67;

  // Our own copy of the channel state. It starts in the reset state, and the
  // block is reset exactly once before any transfer.
  logic [CNT_BITS-1:0] tmr_count = '0;
  logic [CNT_BITS-1:0] tmr_reload = '0;
  logic [CNT_BITS-1:0] tmr_latched = '0;
  logic [2:0]          tmr_mode = MODE_ONESHOT;
  access_t             tmr_access = ACC_BOTH;
  logic [7:0]          tmr_low_hold = 8'h00;
  logic                tmr_wr_high = 1'b0;
  logic                tmr_rd_high = 1'b0;
  logic                tmr_latch_held = 1'b0;
  logic                tmr_pin = 1'b0;
  logic                tmr_running = 1'b0;
  logic                tmr_strobe_spent = 1'b0;

  interval_timer_channel_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .port       (port),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .out_level  (out_level),
    .irq_pulse  (irq_pulse)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The square-wave mode counts by two, so an odd count is first made even:
  // one step longer for the high half, one step shorter for the low half.
  function automatic logic [CNT_BITS-1:0] square_start();
    logic [CNT_BITS-1:0] n;
    n = tmr_reload;
    if (n[0]) begin
      n = tmr_pin ? n + 1'b1 : n - 1'b1;
    end
    return n;
  endfunction

  // A completed count load. The hardware-triggered modes never start, since
  // the gate has no rising edge. The periodic modes that are already running
  // pick up the new count only at the end of the current period.
  function automatic void arm_counter();
    if (tmr_mode == MODE_HW_ONESHOT || tmr_mode == MODE_HW_STROBE) begin
      tmr_running = 1'b0;
    end else if (!((tmr_mode == MODE_RATE || tmr_mode == MODE_SQUARE) && tmr_running)) begin
      tmr_pin = (tmr_mode != MODE_ONESHOT);
      tmr_strobe_spent = 1'b0;
      tmr_count = (tmr_mode == MODE_SQUARE) ? square_start() : tmr_reload;
      tmr_running = 1'b1;
    end
  endfunction

  // Applies one bus access or tick to the channel copy and returns what the
  // block must report for it.
  function automatic result_t timer_step(item_t it);
    result_t             res;
    logic                was_high;
    logic [2:0]          new_mode;
    logic [CNT_BITS-1:0] shown;
    logic                read_done;
    was_high = tmr_pin;
    res = '0;
    case (it.opcode)
      OP_WRITE: begin
        if (it.port == PORT_CMD && it.data[7:6] == CHANNEL_ZERO) begin
          if (access_t'(it.data[5:4]) == ACC_LATCH) begin
            // A second latch before the first is read out is ignored.
            if (!tmr_latch_held) begin
              tmr_latched = tmr_count;
              tmr_latch_held = 1'b1;
            end
          end else begin
            new_mode = it.data[3:1];
            if (new_mode > MODE_HW_STROBE) begin
              new_mode = new_mode - 3'd4;
            end
            tmr_access = access_t'(it.data[5:4]);
            tmr_mode = new_mode;
            tmr_wr_high = 1'b0;
            tmr_rd_high = 1'b0;
            tmr_latch_held = 1'b0;
            tmr_running = 1'b0;
            tmr_strobe_spent = 1'b0;
            tmr_pin = (new_mode != MODE_ONESHOT);
          end
        end else if (it.port == PORT_DATA) begin
          case (tmr_access)
            ACC_LOW: begin
              tmr_reload = CNT_BITS'(it.data);
              arm_counter();
            end
            ACC_HIGH: begin
              tmr_reload = CNT_BITS'({it.data, 8'h00});
              arm_counter();
            end
            default: begin
              if (!tmr_wr_high) begin
                // Half a count in one-shot mode holds the counter.
                tmr_low_hold = it.data;
                tmr_wr_high = 1'b1;
                if (tmr_mode == MODE_ONESHOT) begin
                  tmr_running = 1'b0;
                end
              end else begin
                tmr_reload = CNT_BITS'({it.data, tmr_low_hold});
                tmr_wr_high = 1'b0;
                arm_counter();
              end
            end
          endcase
        end
      end
      OP_READ: begin
        if (it.port == PORT_DATA) begin
          shown = tmr_latch_held ? tmr_latched : tmr_count;
          read_done = 1'b1;
          case (tmr_access)
            ACC_LOW:  res.read_data = shown[7:0];
            ACC_HIGH: res.read_data = shown[15:8];
            default: begin
              if (!tmr_rd_high) begin
                res.read_data = shown[7:0];
                tmr_rd_high = 1'b1;
                read_done = 1'b0;
              end else begin
                res.read_data = shown[15:8];
                tmr_rd_high = 1'b0;
              end
            end
          endcase
          if (read_done) begin
            tmr_latch_held = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (tmr_running) begin
          case (tmr_mode)
            MODE_ONESHOT: begin
              // Past terminal count the counter wraps and the output stays high.
              tmr_count = tmr_count - 1'b1;
              if (tmr_count == '0) begin
                tmr_pin = 1'b1;
              end
            end
            MODE_RATE: begin
              if (tmr_count == CNT_BITS'(1)) begin
                tmr_count = tmr_reload;
                tmr_pin = 1'b1;
              end else begin
                tmr_count = tmr_count - 1'b1;
                if (tmr_count == CNT_BITS'(1)) begin
                  tmr_pin = 1'b0;
                end
              end
            end
            MODE_SQUARE: begin
              tmr_count = tmr_count - CNT_BITS'(2);
              if (tmr_count == '0) begin
                tmr_pin = !tmr_pin;
                tmr_count = square_start();
              end
            end
            MODE_STROBE: begin
              // The strobe is one tick low, and only once per load.
              tmr_pin = 1'b1;
              tmr_count = tmr_count - 1'b1;
              if (tmr_count == '0 && !tmr_strobe_spent) begin
                tmr_pin = 1'b0;
                tmr_strobe_spent = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res.out_level = tmr_pin;
    res.irq_pulse = !was_high && tmr_pin;
    return res;
  endfunction

  task automatic flag_error(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [7:0] cmd_byte(logic [1:0] ch, access_t acc, logic [2:0] m);
    return {ch, acc, m, 1'($urandom_range(1))};
  endfunction

  // Queues one item. Items that the channel merely ignores are not counted
  // toward the size of a phase.
  task automatic add_item(opcode_t op, port_sel_t p, logic [7:0] d);
    item_q.push_back('{opcode: op, port: p, data: d});
    if (!(op == OP_NOP || (op != OP_TICK && (p == PORT_CH1 || p == PORT_CH2)) ||
          (op == OP_READ && p == PORT_CMD) ||
          (op == OP_WRITE && p == PORT_CMD && d[7:6] != CHANNEL_ZERO))) begin
      stim_count++;
    end
  endtask

  task automatic add_noise();
    add_item(opcode_t'(2'($urandom_range(3))), port_sel_t'(2'($urandom_range(3))),
             8'($urandom_range(255)));
  endtask

  task automatic add_tick();
    // The port and data lines carry junk on a tick; the block must ignore them.
    add_item(OP_TICK, port_sel_t'(2'($urandom_range(3))), 8'($urandom_range(255)));
  endtask

  // Writes a count in the bytes that the access kind calls for. With
  // first_only set, a low-then-high load is left half done.
  task automatic add_count_bytes(access_t acc, logic [CNT_BITS-1:0] v, bit first_only);
    case (acc)
      ACC_LOW:  add_item(OP_WRITE, PORT_DATA, v[7:0]);
      ACC_HIGH: add_item(OP_WRITE, PORT_DATA, v[15:8]);
      default: begin
        add_item(OP_WRITE, PORT_DATA, v[7:0]);
        if (!first_only) begin
          add_item(OP_WRITE, PORT_DATA, v[15:8]);
        end
      end
    endcase
  endtask

  // Mostly short counts so the output toggles within a burst of ticks, with
  // zero (the full range) and long counts mixed in.
  function automatic logic [CNT_BITS-1:0] count_pick();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      return CNT_BITS'($urandom_range(1, 24));
    end else if (r < 75) begin
      return '0;
    end else if (r < 85) begin
      return CNT_BITS'($urandom_range(25, 400));
    end
    return CNT_BITS'($urandom_range(65535));
  endfunction

  // Driver: a new item goes out only when the line is free or the current
  // transfer completes at this edge, so valid is assigned once per edge and
  // never drops before its transfer. Prediction happens at acceptance.
  always @(posedge clk) begin : drive_items
    item_t taken;
    logic  fire;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        taken = '{opcode: opcode_t'(opcode), port: port_sel_t'(port), data: write_data};
        expected_q.push_back(timer_step(taken));
      end
      if (!in_valid || fire) begin
        if (item_q.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          taken = item_q.pop_front();
          in_valid <= 1'b1;
          opcode <= taken.opcode;
          port <= taken.port;
          write_data <= taken.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked field by field against the
  // oldest outstanding prediction, and the receiver stalls at random.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_error("result transfer with no result expected");
        end else begin
          want = expected_q.pop_front();
          if (read_data !== want.read_data) begin
            flag_error($sformatf("read_data is %h, expected %h", read_data, want.read_data));
          end
          if (out_level !== want.out_level) begin
            flag_error($sformatf("out_level is %b, expected %b", out_level, want.out_level));
          end
          if (irq_pulse !== want.irq_pulse) begin
            flag_error($sformatf("irq_pulse is %b, expected %b", irq_pulse, want.irq_pulse));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus: a directed opening, then three phases of random programming
  // sequences. Between phases the sender holds off until every expected
  // result has come back.
  initial begin : stimulus
    int                  phase;
    int                  burst;
    int                  pick;
    access_t             acc;
    logic [2:0]          m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reads straight out of reset, then accesses that must change nothing.
    add_item(OP_READ, PORT_DATA, 8'h00);
    add_item(OP_READ, PORT_DATA, 8'hFF);
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ONE, ACC_BOTH, MODE_RATE));
    add_item(OP_WRITE, PORT_CH1, 8'hFF);
    add_item(OP_NOP, PORT_DATA, 8'hFF);
    add_item(OP_READ, PORT_CMD, 8'h00);
    // One-shot with a count of two: output rises at terminal count, then the
    // counter wraps while the output stays high.
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_BOTH, MODE_ONESHOT));
    add_count_bytes(ACC_BOTH, CNT_BITS'(2), 1'b0);
    repeat (3) add_tick();
    // Latch, a second latch that must be ignored, then read the held value.
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_LATCH, MODE_ONESHOT));
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_LATCH, MODE_SQUARE));
    add_tick();
    add_item(OP_READ, PORT_DATA, 8'h00);
    add_item(OP_READ, PORT_DATA, 8'h00);
    // Mode code 6 behaves as the rate generator.
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_LOW, MODE_RATE_ALIAS));
    add_count_bytes(ACC_LOW, CNT_BITS'(2), 1'b0);
    repeat (2) add_tick();
    // Mode code 7 is the square wave; an odd count gives uneven halves.
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_LOW, MODE_SQUARE_ALIAS));
    add_count_bytes(ACC_LOW, CNT_BITS'(5), 1'b0);
    repeat (3) add_tick();
    // Strobe mode loaded with zero, which stands for the full counter range.
    add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, ACC_HIGH, MODE_STROBE));
    add_count_bytes(ACC_HIGH, '0, 1'b0);
    add_tick();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_gap_pct = 20;
          sink_stall_pct = 67;
        end
        1: begin
          sender_gap_pct = 67;
          sink_stall_pct = 20;
        end
        default: begin
          sender_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      stim_count = 0;
      while (stim_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4)) add_noise();
        end else begin
          // A well-formed program: command, count, then a burst of ticks
          // with latches, reads and reloads mixed in.
          m = 3'($urandom_range(7));
          pick = $urandom_range(99);
          acc = (pick < 60) ? ACC_BOTH : (pick < 85) ? ACC_LOW : ACC_HIGH;
          add_item(OP_WRITE, PORT_CMD, cmd_byte(CHANNEL_ZERO, acc, m));
          add_count_bytes(acc, count_pick(), 1'b0);
          burst = $urandom_range(4, 48);
          repeat (burst) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
              add_tick();
            end else if (pick < 76) begin
              add_item(OP_WRITE, PORT_CMD,
                       cmd_byte(CHANNEL_ZERO, ACC_LATCH, 3'($urandom_range(7))));
            end else if (pick < 88) begin
              add_item(OP_READ, PORT_DATA, 8'($urandom_range(255)));
            end else if (pick < 94) begin
              add_count_bytes(acc, count_pick(), $urandom_range(3) == 0);
            end else begin
              add_noise();
            end
          end
        end
      end
      // Hold off until the block has answered everything sent so far. The
      // check runs at the falling edge, after the driver has settled.
      while (item_q.size() != 0 || in_valid || expected_q.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake; the correct run is far shorter than this.
  initial begin : watchdog
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* interval_timer_channel_top.f */
+incdir+rtl
rtl/itc_pkg.sv
rtl/itc_core.sv
rtl/interval_timer_channel_top.sv
bench/interval_timer_channel_top_tb.sv
